// File: hdl/akrt_pkg.sv
// Shared types, constants and register codes for the analog key rapid trigger unit.
`timescale 1ns / 1ps

package akrt_pkg;

  localparam int NUM_KEYS = 64;
  localparam int SAMPLE_BITS = 12;
  localparam int KEY_FIELD_BITS = 6;
  localparam int VALUE_FIELD_BITS = 12;
  localparam int KEY_BITS = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CMP_BITS = SAMPLE_BITS + 2;

  localparam logic [1:0] MODE_STATIC = 2'd0;
  localparam logic [1:0] MODE_DYNAMIC = 2'd1;
  localparam logic [1:0] MODE_CONTINUOUS = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTUATION_MODE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRIP_LEVEL = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRESS_MARGIN = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_MARGIN = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RISE_DELTA = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FALL_DELTA = 3'd5;

  typedef struct packed {
    logic [KEY_FIELD_BITS-1:0]   key_index;
    logic [VALUE_FIELD_BITS-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic [KEY_FIELD_BITS-1:0]   key_id;
    logic                        pressed;
    logic                        changed;
    logic [VALUE_FIELD_BITS-1:0] peak_value;
  } out_item_t;

  typedef struct packed {
    logic                   pressed;
    logic                   armed;
    logic [SAMPLE_BITS-1:0] extremum;
  } key_state_t;

  typedef struct packed {
    logic [1:0]  actuation_mode;
    logic [11:0] trip_level;
    logic [11:0] press_margin;
    logic [11:0] release_margin;
    logic [11:0] rise_delta;
    logic [11:0] fall_delta;
  } cfg_t;

endpackage

// File: hdl/akrt_state_mem.sv
// Per-key state memory with registered read, reset valid bits and same-cycle write bypass.
`timescale 1ns / 1ps

module akrt_state_mem
  import akrt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [KEY_BITS-1:0] rd_addr,
  output key_state_t          rd_data,
  input  logic                wr_en,
  input  logic [KEY_BITS-1:0] wr_addr,
  input  key_state_t          wr_data
);

  key_state_t           mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]  entry_valid;
  key_state_t           mem_q;
  logic                 valid_q;
  logic                 bypass_q;
  key_state_t           bypass_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      bypass_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      valid_q <= 1'b0;
      bypass_q <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= entry_valid[rd_addr];
        bypass_q <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (bypass_q) begin
      rd_data = bypass_data;
    end else if (valid_q) begin
      rd_data = mem_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// File: hdl/akrt_update.sv
// Next-state logic for one key in the static, dynamic and continuous actuation modes.
`timescale 1ns / 1ps

module akrt_update
  import akrt_pkg::*;
(
  input  cfg_t                   cfg,
  input  key_state_t             cur,
  input  logic [SAMPLE_BITS-1:0] value,
  output key_state_t             nxt
);

  logic signed [CMP_BITS-1:0] v;
  logic signed [CMP_BITS-1:0] ext;
  logic signed [CMP_BITS-1:0] ap;
  logic                       above_point;
  key_state_t                 rt;

  always_comb begin
    v = signed'(CMP_BITS'(value));
    ext = signed'(CMP_BITS'(cur.extremum));
    ap = signed'(CMP_BITS'(cfg.trip_level));
    above_point = v > ap;

    rt = cur;
    if (cur.pressed) begin
      if (v > ext) begin
        rt.extremum = value;
      end else if (v < ext - signed'(CMP_BITS'(cfg.fall_delta))) begin
        rt.pressed = 1'b0;
        rt.extremum = value;
      end
    end else begin
      if (v < ext) begin
        rt.extremum = value;
      end else if (v > ext + signed'(CMP_BITS'(cfg.rise_delta))) begin
        rt.pressed = 1'b1;
        rt.extremum = value;
      end
    end

    nxt = cur;
    case (cfg.actuation_mode)
      MODE_STATIC: begin
        if (cur.pressed) begin
          if (v < ap - signed'(CMP_BITS'(cfg.release_margin))) begin
            nxt.pressed = 1'b0;
          end
        end else begin
          if (v > ap + signed'(CMP_BITS'(cfg.press_margin))) begin
            nxt.pressed = 1'b1;
          end
        end
      end
      MODE_DYNAMIC: begin
        if (above_point) begin
          nxt = rt;
        end else begin
          nxt.pressed = 1'b0;
          if (v > ext) begin
            nxt.extremum = value;
          end
        end
      end
      MODE_CONTINUOUS: begin
        if (cur.armed) begin
          nxt = rt;
          if (value == '0) begin
            nxt = '0;
          end
        end else if (above_point) begin
          nxt.pressed = 1'b1;
          nxt.extremum = value;
          nxt.armed = 1'b1;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// File: hdl/analog_key_rapid_trigger_unit.sv
// Top level of the analog key rapid trigger unit: configuration, pipeline and output register.
`timescale 1ns / 1ps
//
// Each input transfer carries one travel sample for one key. The unit keeps,
// per key, a pressed bit, an extremum and a continuous-mode armed flag in a
// 64-entry state memory, and returns exactly one result per sample with the
// key's new pressed state, whether it changed and the extremum after the step.
// An accepted sample reads the memory when it is accepted; when the update
// stage commits, the state is updated, written back and loaded into the
// output register, which then offers the result. Back-to-back samples to the
// same key are forwarded around the memory, so one sample per cycle is taken
// while the receiver does not stall; throughput is one sample per clock then,
// set by the single read-modify-write of the state memory. When the receiver
// stalls, the output register holds its result and one further sample may
// wait in the update stage; in_ready then drops until out_ready returns.
// Reset clears all key state through per-entry valid bits at once and loads
// the register defaults: static mode, actuation point 2048, zero hysteresis,
// sensitivities 64. Configuration writes take effect at the next edge. The
// user must make them while the unit is idle; the unit does not enforce it.

module analog_key_rapid_trigger_unit
  import akrt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t                      cfg;
  logic                      in_fire;
  logic                      commit;
  logic                      s1_valid;
  logic [KEY_FIELD_BITS-1:0] s1_key;
  logic [SAMPLE_BITS-1:0]    s1_value;
  logic                      s1_in_range;
  logic                      in_range;
  key_state_t                cur_state;
  key_state_t                new_state;
  out_item_t                 result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.actuation_mode <= MODE_STATIC;
      cfg.trip_level <= 12'd2048;
      cfg.press_margin <= 12'd0;
      cfg.release_margin <= 12'd0;
      cfg.rise_delta <= 12'd64;
      cfg.fall_delta <= 12'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTUATION_MODE: cfg.actuation_mode <= cfg_data[1:0];
        REG_TRIP_LEVEL:     cfg.trip_level <= cfg_data;
        REG_PRESS_MARGIN:   cfg.press_margin <= cfg_data;
        REG_RELEASE_MARGIN: cfg.release_margin <= cfg_data;
        REG_RISE_DELTA:     cfg.rise_delta <= cfg_data;
        REG_FALL_DELTA:     cfg.fall_delta <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign commit = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || commit;
  assign in_fire = in_valid && in_ready;
  assign in_range = {1'b0, in_data.key_index} < (KEY_FIELD_BITS + 1)'(NUM_KEYS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_key <= in_data.key_index;
      s1_value <= in_data.key_value[SAMPLE_BITS-1:0];
      s1_in_range <= in_range;
    end
  end

  akrt_state_mem u_state_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (in_data.key_index[KEY_BITS-1:0]),
    .rd_data (cur_state),
    .wr_en   (commit && s1_in_range),
    .wr_addr (s1_key[KEY_BITS-1:0]),
    .wr_data (new_state)
  );

  akrt_update u_update (
    .cfg   (cfg),
    .cur   (cur_state),
    .value (s1_value),
    .nxt   (new_state)
  );

  always_comb begin
    result.key_id = s1_key;
    if (s1_in_range) begin
      result.pressed = new_state.pressed;
      result.changed = new_state.pressed ^ cur_state.pressed;
      result.peak_value = VALUE_FIELD_BITS'(new_state.extremum);
    end else begin
      result.pressed = 1'b0;
      result.changed = 1'b0;
      result.peak_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data <= result;
    end
  end

endmodule

// File: tb/akrt_tb_pkg.sv
// Scoreboard class that predicts and checks the per-key actuation results.
`timescale 1ns / 1ps

package akrt_tb_pkg;

  import akrt_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam cfg_t RESET_SETTINGS = '{
    actuation_mode: MODE_STATIC,
    trip_level:     12'd2048,
    press_margin:   12'd0,
    release_margin: 12'd0,
    rise_delta:     12'd64,
    fall_delta:     12'd64
  };

  class key_trigger_scoreboard;
    cfg_t                   settings;
    logic                   key_down [NUM_KEYS];
    logic                   armed [NUM_KEYS];
    logic [SAMPLE_BITS-1:0] extremum [NUM_KEYS];
    out_item_t              awaited [$];
    int unsigned            fail_count;

    function new();
      settings = RESET_SETTINGS;
      fail_count = 0;
      foreach (key_down[k]) begin
        key_down[k] = 1'b0;
        armed[k] = 1'b0;
        extremum[k] = '0;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void track_rapid(int k, int v);
      int ext;
      ext = extremum[k];
      if (key_down[k]) begin
        if (v > ext) begin
          extremum[k] = v[SAMPLE_BITS-1:0];
        end else if (v < ext - int'(settings.fall_delta)) begin
          key_down[k] = 1'b0;
          extremum[k] = v[SAMPLE_BITS-1:0];
        end
      end else begin
        if (v < ext) begin
          extremum[k] = v[SAMPLE_BITS-1:0];
        end else if (v > ext + int'(settings.rise_delta)) begin
          key_down[k] = 1'b1;
          extremum[k] = v[SAMPLE_BITS-1:0];
        end
      end
    endfunction

    function void note_sample(in_item_t item);
      int        k;
      int        v;
      int        ap;
      logic      was_down;
      out_item_t res;
      k = item.key_index;
      v = item.key_value;
      ap = settings.trip_level;
      was_down = key_down[k];
      case (settings.actuation_mode)
        MODE_STATIC: begin
          if (key_down[k]) begin
            if (v < ap - int'(settings.release_margin)) key_down[k] = 1'b0;
          end else if (v > ap + int'(settings.press_margin)) begin
            key_down[k] = 1'b1;
          end
        end
        MODE_DYNAMIC: begin
          if (v > ap) begin
            track_rapid(k, v);
          end else begin
            key_down[k] = 1'b0;
            if (v > int'(extremum[k])) extremum[k] = v[SAMPLE_BITS-1:0];
          end
        end
        MODE_CONTINUOUS: begin
          if (armed[k]) begin
            track_rapid(k, v);
            if (v == 0) begin
              key_down[k] = 1'b0;
              extremum[k] = '0;
              armed[k] = 1'b0;
            end
          end else if (v > ap) begin
            key_down[k] = 1'b1;
            extremum[k] = v[SAMPLE_BITS-1:0];
            armed[k] = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res.key_id = item.key_index;
      res.pressed = key_down[k];
      res.changed = key_down[k] ^ was_down;
      res.peak_value = extremum[k];
      awaited.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $error("Result for key %0d arrived with nothing outstanding.", got.key_id);
        fail_count++;
        return;
      end
      want = awaited.pop_front();
      compare_field("key_id", 32'(want.key_id), 32'(got.key_id));
      compare_field("pressed", 32'(want.pressed), 32'(got.pressed));
      compare_field("changed", 32'(want.changed), 32'(got.changed));
      compare_field("peak_value", 32'(want.peak_value), 32'(got.peak_value));
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// Top-level testbench that drives samples and settings into the rapid trigger unit.
`timescale 1ns / 1ps

module tb_top;

  import akrt_pkg::*;
  import akrt_tb_pkg::*;

  localparam int NUM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam logic [1:0] PHASE_MODES [NUM_PHASES] = '{
    MODE_STATIC, MODE_DYNAMIC, MODE_CONTINUOUS, MODE_STATIC, MODE_DYNAMIC, MODE_CONTINUOUS,
    MODE_DYNAMIC, MODE_CONTINUOUS, MODE_UNUSED, MODE_STATIC, MODE_CONTINUOUS, MODE_DYNAMIC
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid;
  logic                      in_ready;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_ready;
  out_item_t                 out_data;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  key_trigger_scoreboard sb;
  bit                    calm = 1'b0;
  bit                    hold_request = 1'b0;
  int                    travel [NUM_KEYS];

  analog_key_rapid_trigger_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_travel(input int k, input int v);
    in_item_t item;
    item.key_index = KEY_FIELD_BITS'(k);
    item.key_value = VALUE_FIELD_BITS'(v);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(item);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    write_register(REG_ACTUATION_MODE, CFG_DATA_BITS'(s.actuation_mode));
    write_register(REG_TRIP_LEVEL, s.trip_level);
    write_register(REG_PRESS_MARGIN, s.press_margin);
    write_register(REG_RELEASE_MARGIN, s.release_margin);
    write_register(REG_RISE_DELTA, s.rise_delta);
    write_register(REG_FALL_DELTA, s.fall_delta);
    cfg_we <= 1'b0;
    sb.settings = s;
  endtask

  function automatic logic [11:0] random_margin();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'hFFF;
    return 12'($urandom_range(300, 1));
  endfunction

  function automatic cfg_t phase_settings(int p);
    cfg_t s;
    s.actuation_mode = PHASE_MODES[p];
    s.trip_level = 12'($urandom_range(3900, 200));
    s.press_margin = random_margin();
    s.release_margin = random_margin();
    s.rise_delta = random_margin();
    s.fall_delta = random_margin();
    case (p)
      0: begin
        s.trip_level = 12'd0;
        s.press_margin = 12'd0;
        s.release_margin = 12'hFFF;
      end
      1: begin
        s.trip_level = 12'd0;
        s.rise_delta = 12'd0;
        s.fall_delta = 12'd0;
      end
      2: begin
        s.rise_delta = 12'hFFF;
        s.fall_delta = 12'hFFF;
      end
      3: begin
        s.trip_level = 12'hFFF;
        s.press_margin = 12'hFFF;
        s.release_margin = 12'd0;
      end
      7: begin
        s.trip_level = 12'hFFF;
        s.rise_delta = 12'd0;
        s.fall_delta = 12'd0;
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  // Keys follow a random walk of travel, with jumps to the ends of the range
  // and to the actuation point so that every threshold gets crossed.
  function automatic int next_travel(int k);
    int          t;
    int unsigned r;
    r = $urandom_range(99);
    t = travel[k];
    if (r < 8) t = 0;
    else if (r < 12) t = 4095;
    else if (r < 17) t = int'(sb.settings.trip_level) + int'($urandom_range(6)) - 3;
    else if (r < 23) t = int'($urandom_range(4095));
    else t = t + int'($urandom_range(400)) - 200;
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    travel[k] = t;
    return t;
  endfunction

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin : stimulus
    cfg_t        s;
    int          k;
    int unsigned focus [4];
    sb = new();
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (travel[i]) travel[i] = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_travel(0, 4095);
    send_travel(63, 0);
    send_travel(0, 2048);
    send_travel(0, 2047);
    send_travel(63, 2049);
    drain();
    s = RESET_SETTINGS;
    s.actuation_mode = MODE_DYNAMIC;
    apply_settings(s);
    send_travel(63, 3000);
    send_travel(63, 2900);
    send_travel(63, 2990);
    send_travel(63, 1000);
    send_travel(5, 4095);
    send_travel(5, 4095);
    drain();
    s.actuation_mode = MODE_CONTINUOUS;
    apply_settings(s);
    send_travel(63, 2100);
    send_travel(63, 1500);
    send_travel(63, 1600);
    send_travel(63, 0);
    send_travel(5, 0);
    drain();
    s.actuation_mode = MODE_UNUSED;
    apply_settings(s);
    send_travel(5, 2500);
    send_travel(0, 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      apply_settings(phase_settings(p));
      foreach (focus[i]) focus[i] = $urandom_range(NUM_KEYS - 1);
      calm = (p == 5 || p == 6);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 4 && n == 60) hold_request = 1'b1;
        if ($urandom_range(99) < 80) k = focus[$urandom_range(3)];
        else k = $urandom_range(NUM_KEYS - 1);
        send_travel(k, next_travel(k));
      end
    end
    drain();
    repeat (5) @(negedge clk);

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/akrt_pkg.sv
hdl/akrt_state_mem.sv
hdl/akrt_update.sv
hdl/analog_key_rapid_trigger_unit.sv
tb/akrt_tb_pkg.sv
tb/tb_top.sv
